@@ rtl/zigzag_rail_transposer_macros.svh @@
// assertion macros for the zigzag rail transposer
`ifndef ZIGZAG_RAIL_TRANSPOSER_MACROS_SVH
`define ZIGZAG_RAIL_TRANSPOSER_MACROS_SVH

// checked only outside reset
`define ZZRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define ZZRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/zzrt_pkg.sv @@
`default_nettype none

package zzrt_pkg;

  localparam int unsigned MaxLen  = 64;
  localparam int unsigned MaxRows = 16;
  localparam int unsigned AddrW   = $clog2(MaxLen);
  localparam int unsigned CountW  = $clog2(MaxLen + 1);
  localparam int unsigned RowsW   = 5;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       out_last;
    logic       overflow;
  } out_item_t;

  // emission address and end-of-message flag from the rail walker
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic             last;
  } gen_stat_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

@@ rtl/zigzag_rail_transposer.sv @@
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_ready_o  | in_item_i  (char_in, is_last)
// out     | output    | out_valid_o / out_ready_i| out_item_o (char_out, out_last, overflow)
// cfg     | input     | cfg_we_i                 | cfg_wdata_i (num_rows)
//
// loading takes one byte per cycle into a 64 x 8 buffer with a registered read
// emission reads one buffer entry per cycle while the output is not stalled
// the input is closed from the last item until the final byte read is issued
// the buffer read register is the output register: a stall holds the read
// reset sets state, config, counters and flags only; buffer contents need no clearing

`default_nettype none

`include "zigzag_rail_transposer_macros.svh"

module zigzag_rail_transposer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire zzrt_pkg::in_item_t          in_item_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      zzrt_pkg::out_item_t         out_item_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [zzrt_pkg::RowsW-1:0]  cfg_wdata_i
);

  zzrt_pkg::state_e            state_q, state_d;
  logic [zzrt_pkg::RowsW-1:0]  rows_cfg_q;
  logic [zzrt_pkg::CountW-1:0] count_q, count_d;
  logic                        ovf_seen_q, ovf_seen_d;
  logic                        ovf_msg_q, ovf_msg_d;
  logic                        out_valid_q;
  logic [7:0]                  rdata_q;
  logic                        last_q;
  logic                        flag_q;
  logic [7:0]                  mem_q [zzrt_pkg::MaxLen];

  logic                        in_fire, full, wr_en, rd_en, start;
  logic [zzrt_pkg::RowsW-1:0]  rows_eff;
  logic [zzrt_pkg::CountW-1:0] msg_len;
  zzrt_pkg::gen_stat_t         gen;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= zzrt_pkg::RowsW'(1);
    end else if (cfg_we_i) begin
      rows_cfg_q <= cfg_wdata_i;
    end
  end

  // clamp rail count to 1..MaxRows
  always_comb begin
    if (rows_cfg_q == '0) begin
      rows_eff = zzrt_pkg::RowsW'(1);
    end else if (rows_cfg_q > zzrt_pkg::RowsW'(zzrt_pkg::MaxRows)) begin
      rows_eff = zzrt_pkg::RowsW'(zzrt_pkg::MaxRows);
    end else begin
      rows_eff = rows_cfg_q;
    end
  end

  // fsm and load bookkeeping
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ovf_seen_d = ovf_seen_q;
    ovf_msg_d  = ovf_msg_q;
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    full       = count_q == zzrt_pkg::CountW'(zzrt_pkg::MaxLen);
    in_fire    = 1'b0;
    wr_en      = 1'b0;
    start      = 1'b0;
    msg_len    = full ? count_q : count_q + zzrt_pkg::CountW'(1);
    case (state_q)
      zzrt_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        in_fire    = in_valid_i;
        if (in_fire) begin
          wr_en = !full;
          if (full) begin
            ovf_seen_d = 1'b1;
          end else begin
            count_d = msg_len;
          end
          if (in_item_i.is_last) begin
            start      = 1'b1;
            ovf_msg_d  = ovf_seen_q || full;
            count_d    = '0;
            ovf_seen_d = 1'b0;
            state_d    = zzrt_pkg::ST_EMIT;
          end
        end
      end
      zzrt_pkg::ST_EMIT: begin
        rd_en = !out_valid_q || out_ready_i;
        if (rd_en && gen.last) begin
          state_d = zzrt_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = zzrt_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= zzrt_pkg::ST_LOAD;
      count_q    <= '0;
      ovf_seen_q <= 1'b0;
      ovf_msg_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      ovf_seen_q <= ovf_seen_d;
      ovf_msg_q  <= ovf_msg_d;
    end
  end

  // rail-order address walker
  zzrt_rail_gen u_rail_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .rows_i  (rows_eff),
    .len_i   (msg_len),
    .step_i  (rd_en),
    .gen_o   (gen)
  );

  // message buffer; loads and reads never overlap, phases interlock them
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[zzrt_pkg::AddrW-1:0]] <= in_item_i.char_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[gen.addr];
      last_q  <= gen.last;
      flag_q  <= ovf_msg_q;
    end
  end

  // output valid follows the buffer read register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rd_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_item_o.char_out = rdata_q;
  assign out_item_o.out_last = last_q;
  assign out_item_o.overflow = flag_q;

  // checks
  `ZZRT_ASSERT_ALWAYS(a_count_bound, count_q <= zzrt_pkg::CountW'(zzrt_pkg::MaxLen), "byte count past buffer size")
  `ZZRT_ASSERT(a_last_starts_emit, (in_fire && in_item_i.is_last) |=> (state_q == zzrt_pkg::ST_EMIT && count_q == '0 && !ovf_seen_q), "last item did not start emission")
  `ZZRT_ASSERT(a_final_read_ends, (rd_en && gen.last) |=> (state_q == zzrt_pkg::ST_LOAD && out_valid_o && out_item_o.out_last), "final read did not end emission")
  `ZZRT_ASSERT(a_no_write_in_emit, (state_q == zzrt_pkg::ST_EMIT) |-> (!wr_en && !start), "buffer written during emission")

endmodule

`default_nettype wire

@@ rtl/zzrt_rail_gen.sv @@
`default_nettype none

module zzrt_rail_gen (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [zzrt_pkg::RowsW-1:0]    rows_i,
  input  wire logic [zzrt_pkg::CountW-1:0]   len_i,
  input  wire logic                          step_i,
  output zzrt_pkg::gen_stat_t                gen_o
);

  logic [zzrt_pkg::AddrW-1:0]  idx_q, idx_d;
  logic [zzrt_pkg::RowsW-1:0]  rail_q, rail_d;
  logic                        phase_q, phase_d;
  logic [zzrt_pkg::RowsW-1:0]  rows_q, rows_d;
  logic [zzrt_pkg::RowsW-1:0]  per_q, per_d;
  logic [zzrt_pkg::CountW-1:0] len_q, len_d;

  logic [zzrt_pkg::RowsW-1:0]  step_down, step_up, step;
  logic [zzrt_pkg::CountW:0]   nxt;
  logic [zzrt_pkg::RowsW-1:0]  rail_nxt;
  logic                        in_rail, done;

  // zigzag strides: down to the mirror rail, then up to the next period
  always_comb begin
    step_down = per_q - {rail_q[zzrt_pkg::RowsW-2:0], 1'b0};
    step_up   = {rail_q[zzrt_pkg::RowsW-2:0], 1'b0};
    if (rows_q == zzrt_pkg::RowsW'(1)) begin
      step = zzrt_pkg::RowsW'(1);
    end else if (phase_q) begin
      step = (step_up == '0) ? step_down : step_up;
    end else begin
      step = (step_down == '0) ? step_up : step_down;
    end
    nxt      = (zzrt_pkg::CountW + 1)'(idx_q) + (zzrt_pkg::CountW + 1)'(step);
    rail_nxt = rail_q + zzrt_pkg::RowsW'(1);
    in_rail  = nxt < (zzrt_pkg::CountW + 1)'(len_q);
    done     = !in_rail && ((rail_nxt >= rows_q) ||
                            (zzrt_pkg::CountW'(rail_nxt) >= len_q));
  end

  // walker update
  always_comb begin
    idx_d   = idx_q;
    rail_d  = rail_q;
    phase_d = phase_q;
    rows_d  = rows_q;
    per_d   = per_q;
    len_d   = len_q;
    if (start_i) begin
      idx_d   = '0;
      rail_d  = '0;
      phase_d = 1'b0;
      rows_d  = rows_i;
      per_d   = {rows_i[zzrt_pkg::RowsW-2:0] - (zzrt_pkg::RowsW - 1)'(1), 1'b0};
      len_d   = len_i;
    end else if (step_i) begin
      if (in_rail) begin
        idx_d   = nxt[zzrt_pkg::AddrW-1:0];
        phase_d = !phase_q;
      end else if (!done) begin
        rail_d  = rail_nxt;
        idx_d   = zzrt_pkg::AddrW'(rail_nxt);
        phase_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      rail_q  <= '0;
      phase_q <= 1'b0;
      rows_q  <= zzrt_pkg::RowsW'(1);
      per_q   <= '0;
      len_q   <= '0;
    end else begin
      idx_q   <= idx_d;
      rail_q  <= rail_d;
      phase_q <= phase_d;
      rows_q  <= rows_d;
      per_q   <= per_d;
      len_q   <= len_d;
    end
  end

  assign gen_o.addr = idx_q;
  assign gen_o.last = done;

endmodule

`default_nettype wire
